### src/mi3inv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3inv_pkg
// Shared types and constants of the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package mi3inv_pkg;

    localparam int unsigned EntryWidth = 32;
    localparam int unsigned CofWidth   = 65;
    localparam int unsigned CmagWidth  = 64;
    localparam int unsigned DetWidth   = 98;
    localparam int unsigned MagWidth   = 97;
    localparam int unsigned QuoWidth   = 32;
    localparam int unsigned NumEntries = 9;
    localparam int unsigned Latency    = 39;

    localparam logic [EntryWidth-1:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [EntryWidth-1:0] SatNeg = 32'h8000_0000;
    localparam logic [EntryWidth-1:0] ThresholdReset = 32'd1;

    typedef logic signed [EntryWidth-1:0] entry_t;
    typedef logic signed [CofWidth-1:0]   cof_t;
    typedef logic [CmagWidth-1:0]         cmag_t;
    typedef logic signed [DetWidth-1:0]   det_t;
    typedef logic [MagWidth-1:0]          mag_t;
    typedef logic [QuoWidth-1:0]          quo_t;

    typedef struct packed {
        logic sing;
        logic dneg;
    } div_ctl_t;

    typedef struct packed {
        logic sing;
        logic neg;
        logic ovf;
    } div_info_t;

endpackage
`default_nettype wire

### src/mi3inv_adjugate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3inv_adjugate
// Four stages: cofactor products, cofactors, split determinant products,
// determinant sum.
// ----------------------------------------------------------------------------
module mi3inv_adjugate
    import mi3inv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  entry_t      m [NumEntries],
    output logic        out_valid,
    output cof_t        adj [NumEntries],
    output det_t        det
);

    localparam int unsigned CA [NumEntries] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned CB [NumEntries] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned CC [NumEntries] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned CD [NumEntries] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [63:0] pa_reg [NumEntries];
    logic signed [63:0] pb_reg [NumEntries];
    entry_t m1_reg [3];
    entry_t m2_reg [3];
    cof_t   cof2_reg [NumEntries];
    cof_t   cof3_reg [NumEntries];
    cof_t   cof4_reg [NumEntries];
    logic signed [64:0] lo3_reg [3];
    logic signed [64:0] hi3_reg [3];
    det_t   det4_reg;
    det_t   det_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NumEntries; j++)
        begin
            pa_reg[j]   <= 64'(m[CA[j]]) * 64'(m[CB[j]]);
            pb_reg[j]   <= 64'(m[CC[j]]) * 64'(m[CD[j]]);
            cof2_reg[j] <= 65'(pa_reg[j]) - 65'(pb_reg[j]);
            cof3_reg[j] <= cof2_reg[j];
            cof4_reg[j] <= cof3_reg[j];
        end
        for (int k = 0; k < 3; k++)
        begin
            m1_reg[k]  <= m[k];
            m2_reg[k]  <= m1_reg[k];
            lo3_reg[k] <= 65'($signed({1'b0, cof2_reg[3*k][31:0]})) * 65'(m2_reg[k]);
            hi3_reg[k] <= 65'($signed(cof2_reg[3*k][64:32])) * 65'(m2_reg[k]);
        end
        det4_reg <= det_next;
    end

    always_comb
    begin
        det_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            det_next = det_next + (98'(hi3_reg[k]) << 32) + 98'(lo3_reg[k]);
        end
    end

    assign out_valid = v4_reg;
    assign adj       = cof4_reg;
    assign det       = det4_reg;

endmodule
`default_nettype wire

### src/mi3inv_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3inv_divider
// One inverse entry: magnitude and range check, one restoring quotient bit
// per stage, then sign, saturation and singular masking.
// ----------------------------------------------------------------------------
module mi3inv_divider
    import mi3inv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  div_ctl_t    ctl,
    input  cof_t        cof,
    input  mag_t        dmag,
    output logic        out_valid,
    output logic        out_sing,
    output entry_t      quo
);

    logic      vld_reg  [QuoWidth+1];
    div_info_t info_reg [QuoWidth+1];
    mag_t      r_reg    [QuoWidth+1];
    mag_t      d_reg    [QuoWidth+1];
    quo_t      q_reg    [QuoWidth+1];
    logic      out_valid_reg;
    logic      out_sing_reg;
    entry_t    quo_reg;
    cmag_t     cmag;
    div_info_t info_next;
    entry_t    quo_next;

    always_comb
    begin
        cmag           = cof[CofWidth-1] ? CmagWidth'(-cof) : CmagWidth'(cof);
        info_next.sing = ctl.sing;
        info_next.neg  = cof[CofWidth-1] ^ ctl.dneg;
        info_next.ovf  = MagWidth'(cmag) >= dmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg[0] <= info_next;
        r_reg[0]    <= MagWidth'(cmag);
        d_reg[0]    <= dmag;
        q_reg[0]    <= '0;
    end

    for (genvar s = 1; s <= QuoWidth; s++)
    begin : g_step
        logic [MagWidth:0] r2;
        logic [MagWidth:0] dd;
        logic              ge;

        always_comb
        begin
            r2 = {r_reg[s-1], 1'b0};
            dd = {1'b0, d_reg[s-1]};
            ge = r2 >= dd;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            info_reg[s] <= info_reg[s-1];
            d_reg[s]    <= d_reg[s-1];
            r_reg[s]    <= ge ? MagWidth'(r2 - dd) : r2[MagWidth-1:0];
            q_reg[s]    <= {q_reg[s-1][QuoWidth-2:0], ge};
        end
    end

    always_comb
    begin
        priority if (info_reg[QuoWidth].sing)
        begin
            quo_next = '0;
        end
        else if (!info_reg[QuoWidth].neg)
        begin
            if (info_reg[QuoWidth].ovf || q_reg[QuoWidth][QuoWidth-1])
                quo_next = SatPos;
            else
                quo_next = q_reg[QuoWidth];
        end
        else
        begin
            if (info_reg[QuoWidth].ovf || q_reg[QuoWidth] > SatNeg)
                quo_next = SatNeg;
            else
                quo_next = -q_reg[QuoWidth];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= vld_reg[QuoWidth];
        end
    end

    always_ff @(posedge clk)
    begin
        out_sing_reg <= info_reg[QuoWidth].sing;
        quo_reg      <= quo_next;
    end

    assign out_valid = out_valid_reg;
    assign out_sing  = out_sing_reg;
    assign quo       = quo_reg;

endmodule
`default_nettype wire

### src/matrix3x3_inverse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Pipeline from the start edge to the done cycle: 5 adjugate and
// determinant stages, then an input register, 32 restoring quotient stages
// and an output register in the divider.
// Throughput: one matrix per cycle; busy stays low, the receiver cannot stall.
// Reset clears all valid bits and sets the threshold register to 1.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core
    import mi3inv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        threshold_we,
    input  wire logic [31:0] threshold_data,
    input  entry_t           in_r1c1,
    input  entry_t           in_r1c2,
    input  entry_t           in_r1c3,
    input  entry_t           in_r2c1,
    input  entry_t           in_r2c2,
    input  entry_t           in_r2c3,
    input  entry_t           in_r3c1,
    input  entry_t           in_r3c2,
    input  entry_t           in_r3c3,
    output logic             done,
    output entry_t           inv_r1c1,
    output entry_t           inv_r1c2,
    output entry_t           inv_r1c3,
    output entry_t           inv_r2c1,
    output entry_t           inv_r2c2,
    output entry_t           inv_r2c3,
    output entry_t           inv_r3c1,
    output entry_t           inv_r3c2,
    output entry_t           inv_r3c3,
    output logic             singular
);

    entry_t        m [NumEntries];
    entry_t        res [NumEntries];
    logic          res_valid [NumEntries];
    logic          res_sing  [NumEntries];
    logic          adj_valid;
    cof_t          adj [NumEntries];
    det_t          det;
    logic [31:0]   thr_reg;
    logic          v5_reg;
    cof_t          cof5_reg [NumEntries];
    mag_t          dmag5_reg;
    div_ctl_t      ctl5_reg;
    mag_t          dmag_next;
    div_ctl_t      ctl_next;

    assign m[0] = in_r1c1;
    assign m[1] = in_r1c2;
    assign m[2] = in_r1c3;
    assign m[3] = in_r2c1;
    assign m[4] = in_r2c2;
    assign m[5] = in_r2c3;
    assign m[6] = in_r3c1;
    assign m[7] = in_r3c2;
    assign m[8] = in_r3c3;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= ThresholdReset;
        end
        else if (threshold_we)
        begin
            thr_reg <= threshold_data;
        end
    end

    mi3inv_adjugate u_adjugate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .m         (m),
        .out_valid (adj_valid),
        .adj       (adj),
        .det       (det)
    );

    always_comb
    begin
        dmag_next     = det[DetWidth-1] ? MagWidth'(-det) : MagWidth'(det);
        ctl_next.dneg = det[DetWidth-1];
        ctl_next.sing = (dmag_next == '0) || (dmag_next < MagWidth'({thr_reg, 32'd0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= adj_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cof5_reg  <= adj;
        dmag5_reg <= dmag_next;
        ctl5_reg  <= ctl_next;
    end

    for (genvar j = 0; j < NumEntries; j++)
    begin : g_div
        mi3inv_divider u_divider (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v5_reg),
            .ctl       (ctl5_reg),
            .cof       (cof5_reg[j]),
            .dmag      (dmag5_reg),
            .out_valid (res_valid[j]),
            .out_sing  (res_sing[j]),
            .quo       (res[j])
        );
    end

    assign done     = res_valid[0] & res_valid[8];
    assign singular = res_sing[0] & res_sing[8];
    assign inv_r1c1 = res[0];
    assign inv_r1c2 = res[1];
    assign inv_r1c3 = res[2];
    assign inv_r2c1 = res[3];
    assign inv_r2c2 = res[4];
    assign inv_r2c3 = res[5];
    assign inv_r3c1 = res[6];
    assign inv_r3c2 = res[7];
    assign inv_r3c3 = res[8];

endmodule
`default_nettype wire

### src/mi3inv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3inv_checker
// Port-level timing and result checks, bound to the core.
// ----------------------------------------------------------------------------
module mi3inv_checker
    import mi3inv_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   start,
    input wire logic   busy,
    input wire logic   done,
    input wire logic   singular,
    input entry_t      inv_r1c1,
    input entry_t      inv_r2c2,
    input entry_t      inv_r3c3
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##Latency done)
        else $error("word accepted without result at fixed latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, Latency))
        else $error("result with no matching accepted word");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (inv_r1c1 == '0 && inv_r2c2 == '0 && inv_r3c3 == '0))
        else $error("singular word carries nonzero entries");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !done)
        else $error("result strobe during reset");

endmodule

bind matrix3x3_inverse_core mi3inv_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .singular (singular),
    .inv_r1c1 (inv_r1c1),
    .inv_r2c2 (inv_r2c2),
    .inv_r3c3 (inv_r3c3)
);
`default_nettype wire

### dv/matrix3x3_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_checker
// Watches the command and result channels of the 3x3 inverse core, computes
// each expected inverse with exact wide integer arithmetic, and compares
// every done word field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_checker
    import mi3inv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        threshold_we,
    input  logic [31:0] threshold_data,
    input  logic [8:0][31:0] mat,
    input  logic        done,
    input  logic [8:0][31:0] inv,
    input  logic        singular,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic             sing;
        logic [8:0][31:0] e;
    } inv_word_t;

    logic [31:0] threshold_q;
    inv_word_t   inverse_q[$];

    function automatic inv_word_t solve_inverse(logic [8:0][31:0] m, logic [31:0] thr);
        logic signed [127:0] a[9];
        logic signed [127:0] cof[9];
        logic signed [127:0] det;
        logic [127:0] mag, lim, cm, q;
        logic neg;
        inv_word_t r;
        for (int i = 0; i < 9; i++)
            a[i] = {{96{m[i][31]}}, m[i]};
        cof[0] = a[4] * a[8] - a[5] * a[7];
        cof[1] = a[2] * a[7] - a[1] * a[8];
        cof[2] = a[1] * a[5] - a[2] * a[4];
        cof[3] = a[5] * a[6] - a[3] * a[8];
        cof[4] = a[0] * a[8] - a[2] * a[6];
        cof[5] = a[2] * a[3] - a[0] * a[5];
        cof[6] = a[3] * a[7] - a[4] * a[6];
        cof[7] = a[1] * a[6] - a[0] * a[7];
        cof[8] = a[0] * a[4] - a[1] * a[3];
        det = cof[0] * a[0] + cof[3] * a[1] + cof[6] * a[2];
        mag = det[127] ? -det : det;
        lim = {64'd0, thr, 32'd0};
        r = '0;
        if (mag == 0 || mag < lim) begin
            r.sing = 1'b1;
            return r;
        end
        for (int i = 0; i < 9; i++) begin
            cm  = cof[i][127] ? -cof[i] : cof[i];
            q   = (cm << 32) / mag;
            neg = cof[i][127] != det[127];
            if (!neg)
                r.e[i] = (q > 128'h7FFF_FFFF) ? SatPos : q[31:0];
            else
                r.e[i] = (q > 128'h8000_0000) ? SatNeg : 32'(-q[31:0]);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            threshold_q <= ThresholdReset;
        end else begin
            if (threshold_we)
                threshold_q <= threshold_data;
            if (start && !busy)
                inverse_q.push_back(solve_inverse(mat, threshold_q));
            if (done) begin
                if (inverse_q.size() == 0) begin
                    $display("%0t: unexpected result word", $time);
                    errors++;
                end else begin
                    inv_word_t x;
                    x = inverse_q.pop_front();
                    if (x.sing !== singular) begin
                        $display("%0t: singular expected %0b actual %0b", $time, x.sing,
                                 singular);
                        errors++;
                    end
                    for (int i = 0; i < 9; i++)
                        if (x.e[i] !== inv[i]) begin
                            $display("%0t: entry %0d expected %h actual %h", $time, i,
                                     x.e[i], inv[i]);
                            errors++;
                        end
                end
            end
        end
    end

    initial errors = 0;
    assign pending = inverse_q.size();

endmodule

### dv/tb_matrix3x3_inverse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse_core
// Drives directed and random matrices into the 3x3 inverse core in bursts,
// across several singularity thresholds, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse_core;
    import mi3inv_pkg::*;

    logic clk, rst_n, start, busy, threshold_we, done, singular;
    logic [31:0] threshold_data;
    logic [8:0][31:0] mat, inv;
    int errors, pending, burst_left;
    logic start_low;

    always
    begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    matrix3x3_inverse_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .threshold_we(threshold_we), .threshold_data(threshold_data),
        .in_r1c1(mat[0]), .in_r1c2(mat[1]), .in_r1c3(mat[2]),
        .in_r2c1(mat[3]), .in_r2c2(mat[4]), .in_r2c3(mat[5]),
        .in_r3c1(mat[6]), .in_r3c2(mat[7]), .in_r3c3(mat[8]),
        .done(done),
        .inv_r1c1(inv[0]), .inv_r1c2(inv[1]), .inv_r1c3(inv[2]),
        .inv_r2c1(inv[3]), .inv_r2c2(inv[4]), .inv_r2c3(inv[5]),
        .inv_r3c1(inv[6]), .inv_r3c2(inv[7]), .inv_r3c3(inv[8]),
        .singular(singular)
    );

    matrix3x3_inverse_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .threshold_we(threshold_we), .threshold_data(threshold_data), .mat(mat),
        .done(done), .inv(inv), .singular(singular), .errors(errors), .pending(pending)
    );

    function automatic logic [8:0][31:0] diag(logic [31:0] v);
        logic [8:0][31:0] m;
        m = '0;
        m[0] = v; m[4] = v; m[8] = v;
        return m;
    endfunction

    function automatic logic [31:0] small_entry(int bits);
        return $urandom_range(0, (1 << bits) - 1) - (1 << (bits - 1));
    endfunction

    function automatic logic [8:0][31:0] random_matrix();
        logic [8:0][31:0] m;
        int kind, bits;
        kind = $urandom_range(0, 9);
        bits = $urandom_range(3, 20);
        for (int i = 0; i < 9; i++)
            m[i] = (kind < 2) ? $urandom() : small_entry(bits);
        if (kind == 9)
            for (int i = 0; i < 3; i++)
                m[6 + i] = m[i] + m[3 + i];
        else if (kind == 8)
            for (int i = 0; i < 3; i++)
                m[4 * i] = m[4 * i] + (32'd1 << $urandom_range(0, 24));
        return m;
    endfunction

    task automatic push_matrix(logic [8:0][31:0] m);
        int gap;
        start <= 1'b1;
        mat   <= m;
        start_low = 1'b0;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                start_low = 1'b1;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_and_set(logic [31:0] thr);
        if (!start_low) begin
            start <= 1'b0;
            start_low = 1'b1;
        end
        wait (pending == 0);
        repeat (Latency + 5) @(posedge clk);
        threshold_we   <= 1'b1;
        threshold_data <= thr;
        @(posedge clk);
        threshold_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_set();
        logic [8:0][31:0] m;
        push_matrix(diag(32'h0001_0000));
        push_matrix('0);
        push_matrix({9{32'h7FFF_FFFF}});
        push_matrix({9{32'h8000_0000}});
        push_matrix(diag(32'h8000_0000));
        push_matrix(diag(32'h7FFF_FFFF));
        push_matrix(diag(32'd1));
        push_matrix(diag(32'hFFFF_FFFF));
        push_matrix(diag(32'd2));
        push_matrix(diag(32'hFFFF_FFFE));
        push_matrix(diag(32'h100));
        push_matrix(diag(32'h0040_0000));
        m = diag(32'h0002_0000);
        m[1] = 32'hFFFF_0000; m[5] = 32'h0003_8000; m[6] = 32'h8000_0000;
        push_matrix(m);
        m = {32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd5, 32'd7, 32'd9};
        push_matrix(m);
    endtask

    initial
    begin
        logic [31:0] thr_list[5];
        rst_n = 1'b0;
        start = 1'b0;
        threshold_we = 1'b0;
        threshold_data = '0;
        mat = '0;
        start_low = 1'b1;
        burst_left = $urandom_range(1, 20);
        thr_list = '{32'hFFFF_FFFF, 32'h0001_0000, $urandom(), 32'd1, 32'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_set();
        drain_and_set(32'd0);
        directed_set();
        foreach (thr_list[p]) begin
            drain_and_set(thr_list[p]);
            repeat (95) push_matrix(random_matrix());
        end
        drain_and_set(32'd1);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
